[rtl/core/dual_channel_average_to_percent_top_assert.svh]
// ----------------------------------------------------------------------------
// dual channel average to percent: assertion macros
// property wrappers shared by the asserting modules of the block
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_AVERAGE_TO_PERCENT_TOP_ASSERT_SVH
`define DUAL_CHANNEL_AVERAGE_TO_PERCENT_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DCAP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DCAP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/dcap_pkg.sv]
// ----------------------------------------------------------------------------
// dcap_pkg
// shared widths, codes and interface types of the dual channel averager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcap_pkg;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int CAL_W     = 16;
   localparam int PCT_W     = 8;
   localparam int CSR_IDX_W = 8;

   // shared bit-serial divider: dividend width covers the largest window sum
   // and the largest scaled percent numerator
   localparam int DIV_W   = 24;
   localparam int QCNT_W  = $clog2(DIV_W);
   localparam int NUMER_W = 23;

   // percent codes
   localparam logic [PCT_W-1:0] PCT_INVALID = 8'hFF;
   localparam logic [PCT_W-1:0] PCT_FULL    = 8'd100;
   localparam logic [PCT_W-1:0] PCT_ZERO    = 8'd0;

   // calibration reset levels
   localparam logic [CAL_W-1:0] DRY_RESET = 16'hFFFF;
   localparam logic [CAL_W-1:0] WET_RESET = 16'h0000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DRY_A = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WET_A = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_B = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WET_B = 8'd3;

   // percent mapping outcome
   localparam logic [1:0] OUT_INVALID = 2'd0;
   localparam logic [1:0] OUT_ZERO    = 2'd1;
   localparam logic [1:0] OUT_FULL    = 2'd2;
   localparam logic [1:0] OUT_DIVIDE  = 2'd3;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [CAL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_sts_type;

   typedef struct packed {
      logic               done;
      logic [1:0]         outcome;
      logic [NUMER_W-1:0] numer;
      logic [CAL_W-1:0]   span;
   } pct_sts_type;

endpackage

[rtl/core/dual_channel_average_to_percent_top.sv]
// ----------------------------------------------------------------------------
// dual_channel_average_to_percent_top
// two channel window averager with calibrated percent output
// ----------------------------------------------------------------------------
// Each req transfer carries one sample of each channel. A pair that does not
// complete the window of WINDOW_PAIRS pairs gives no result, and req_tready
// stays high for further pairs. The pair that completes the window starts the
// result sequence: the two rounded means and then the two percents (each one
// that the percent set-up does not clamp) go one after another through a
// single bit-serial divider that yields one quotient bit per cycle; each
// percent first passes the percent set-up. During the whole sequence
// req_tready is low. A pair flagged with a conversion error aborts the window
// and gives a failed result with no division. Results wait in an output
// register, so a stalled rsp side only holds the block once the next result
// is ready.
`timescale 1ns / 1ps
`include "dual_channel_average_to_percent_top_assert.svh"

module dual_channel_average_to_percent_top import dcap_pkg::*; #(
   parameter int WINDOW_PAIRS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // sample pairs
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // sample_a, sample_b
   input  logic [0:0]           req_tuser,   // conversion_error
   // results
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,   // level_a, level_b, percent_a,
                                             // percent_b, valid_a, valid_b, pad
   output logic [0:0]           rsp_tuser,   // read_failed
   // calibration registers
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_data
);

   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_PAIRS);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MEAN = 3'd1;
   localparam logic [2:0] S_PREP = 3'd2;
   localparam logic [2:0] S_PDIV = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                ch_ff, ch_in;
   logic                div_go_ff, div_go_in;
   logic                prep_go_ff, prep_go_in;

   logic [CAL_W-1:0]    lvl_a_ff, lvl_a_in;
   logic [CAL_W-1:0]    lvl_b_ff, lvl_b_in;
   logic [PCT_W-1:0]    pct_a_ff, pct_a_in;
   logic [PCT_W-1:0]    pct_b_ff, pct_b_in;
   logic                ok_a_ff, ok_a_in;
   logic                ok_b_ff, ok_b_in;
   logic                fail_ff, fail_in;

   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [55:0]         rsp_tdata_ff;
   logic                rsp_tuser_ff;

   logic [CAL_W-1:0]    dry_a_ff, wet_a_ff, dry_b_ff, wet_b_ff;

   logic                req_fire;
   logic                req_err;
   logic                push_fire;
   logic                acc_add;
   logic                acc_clear;
   logic                acc_last;
   logic [SUM_W-1:0]    sum_a;
   logic [SUM_W-1:0]    sum_b;

   div_req_type         div_req;
   div_sts_type         div_sts;
   pct_sts_type         pct_sts;

   logic [CAL_W-1:0]    prep_level;
   logic [CAL_W-1:0]    prep_dry;
   logic [CAL_W-1:0]    prep_wet;
   logic [PCT_W-1:0]    pct_value;
   logic                pct_ok;
   logic                pct_ready;

   // handshakes
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_err    = req_tuser[0];
   assign push_fire  = (state_ff == S_PUSH) & (~rsp_tvalid_ff | rsp_tready);
   assign acc_add    = req_fire & ~req_err;
   assign acc_clear  = (req_fire & req_err) | push_fire;
   assign csr_ready  = 1'b1;

   // calibration register writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         dry_a_ff <= DRY_RESET;
         wet_a_ff <= WET_RESET;
         dry_b_ff <= DRY_RESET;
         wet_b_ff <= WET_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DRY_A: dry_a_ff <= csr_data;
            REG_WET_A: wet_a_ff <= csr_data;
            REG_DRY_B: dry_b_ff <= csr_data;
            REG_WET_B: wet_b_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   dcap_accum #(
      .WINDOW_PAIRS (WINDOW_PAIRS),
      .SUM_W        (SUM_W)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .add      (acc_add),
      .clear    (acc_clear),
      .sample_a (req_tdata[15:0]),
      .sample_b (req_tdata[31:16]),
      .sum_a    (sum_a),
      .sum_b    (sum_b),
      .last     (acc_last)
   );

   // divider operands: rounded window mean or scaled percent
   always_comb begin
      div_req.start = div_go_ff;
      if (state_ff == S_MEAN) begin
         div_req.dividend = DIV_W'(ch_ff ? sum_b : sum_a) + DIV_W'(WINDOW_PAIRS / 2);
         div_req.divisor  = CAL_W'(WINDOW_PAIRS);
      end else begin
         div_req.dividend = DIV_W'(pct_sts.numer);
         div_req.divisor  = pct_sts.span;
      end
   end

   dcap_serial_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .sts   (div_sts)
   );

   // percent set-up for the channel in hand
   assign prep_level = ch_ff ? lvl_b_ff : lvl_a_ff;
   assign prep_dry   = ch_ff ? dry_b_ff : dry_a_ff;
   assign prep_wet   = ch_ff ? wet_b_ff : wet_a_ff;

   dcap_pct_prep u_prep (
      .clock (clock),
      .reset (reset),
      .load  (prep_go_ff),
      .level (prep_level),
      .dry   (prep_dry),
      .wet   (prep_wet),
      .sts   (pct_sts)
   );

   // percent of the channel in hand, from the clamp result or the quotient
   always_comb begin
      pct_value = div_sts.quotient[PCT_W-1:0];
      pct_ok    = 1'b1;
      pct_ready = 1'b0;
      if (state_ff == S_PDIV) begin
         pct_ready = div_sts.done;
      end else if ((state_ff == S_PREP) && pct_sts.done) begin
         pct_ready = (pct_sts.outcome != OUT_DIVIDE);
         case (pct_sts.outcome)
            OUT_INVALID: begin
               pct_value = PCT_INVALID;
               pct_ok    = 1'b0;
            end
            OUT_ZERO: pct_value = PCT_ZERO;
            OUT_FULL: pct_value = PCT_FULL;
            default:  pct_value = div_sts.quotient[PCT_W-1:0];
         endcase
      end
   end

   // result sequencer
   always_comb begin
      state_in   = state_ff;
      ch_in      = ch_ff;
      div_go_in  = 1'b0;
      prep_go_in = 1'b0;
      lvl_a_in   = lvl_a_ff;
      lvl_b_in   = lvl_b_ff;
      pct_a_in   = pct_a_ff;
      pct_b_in   = pct_b_ff;
      ok_a_in    = ok_a_ff;
      ok_b_in    = ok_b_ff;
      fail_in    = fail_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_err) begin
               lvl_a_in = '0;
               lvl_b_in = '0;
               pct_a_in = PCT_INVALID;
               pct_b_in = PCT_INVALID;
               ok_a_in  = 1'b0;
               ok_b_in  = 1'b0;
               fail_in  = 1'b1;
               state_in = S_PUSH;
            end else if (req_fire && acc_last) begin
               fail_in   = 1'b0;
               ch_in     = 1'b0;
               div_go_in = 1'b1;
               state_in  = S_MEAN;
            end
         end
         S_MEAN: begin
            if (div_sts.done) begin
               if (ch_ff) begin
                  lvl_b_in   = div_sts.quotient[CAL_W-1:0];
                  ch_in      = 1'b0;
                  prep_go_in = 1'b1;
                  state_in   = S_PREP;
               end else begin
                  lvl_a_in  = div_sts.quotient[CAL_W-1:0];
                  ch_in     = 1'b1;
                  div_go_in = 1'b1;
               end
            end
         end
         S_PREP: begin
            if (pct_sts.done && (pct_sts.outcome == OUT_DIVIDE)) begin
               div_go_in = 1'b1;
               state_in  = S_PDIV;
            end
         end
         S_PDIV: begin
         end
         S_PUSH: begin
            if (push_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // channel percent settled: store it, then next channel or push
      if (pct_ready) begin
         if (ch_ff) begin
            pct_b_in = pct_value;
            ok_b_in  = pct_ok;
            state_in = S_PUSH;
         end else begin
            pct_a_in   = pct_value;
            ok_a_in    = pct_ok;
            ch_in      = 1'b1;
            prep_go_in = 1'b1;
            state_in   = S_PREP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ch_ff      <= 1'b0;
         div_go_ff  <= 1'b0;
         prep_go_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ch_ff      <= ch_in;
         div_go_ff  <= div_go_in;
         prep_go_ff <= prep_go_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_a_ff <= lvl_a_in;
      lvl_b_ff <= lvl_b_in;
      pct_a_ff <= pct_a_in;
      pct_b_ff <= pct_b_in;
      ok_a_ff  <= ok_a_in;
      ok_b_ff  <= ok_b_in;
      fail_ff  <= fail_in;
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      if (push_fire) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         rsp_tdata_ff <= {6'd0, ok_b_ff, ok_a_ff, pct_b_ff, pct_a_ff, lvl_b_ff, lvl_a_ff};
         rsp_tuser_ff <= fail_ff;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

   // checks
   `DCAP_ASSERT_NOW(a_fail_fields, clock, reset, rsp_tvalid && rsp_tuser[0],
      rsp_tdata[39:32] == PCT_INVALID && rsp_tdata[47:40] == PCT_INVALID &&
      rsp_tdata[49:48] == 2'b00, "failed result carries live percent fields")
   `DCAP_ASSERT_NOW(a_pct_a_range, clock, reset, rsp_tvalid && rsp_tdata[48],
      rsp_tdata[39:32] <= PCT_FULL, "valid channel a percent above full scale")
   `DCAP_ASSERT_NOW(a_div_done_state, clock, reset, div_sts.done,
      state_ff == S_MEAN || state_ff == S_PDIV, "divider finished outside a divide state")
   `DCAP_ASSERT_NEXT(a_window_close, clock, reset, req_fire && (req_err || acc_last),
      state_ff != S_IDLE, "completing transfer did not start the result sequence")

endmodule

[rtl/core/dcap_accum.sv]
// ----------------------------------------------------------------------------
// dcap_accum
// window sums of both channels and the pair counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcap_accum import dcap_pkg::*; #(
   parameter int WINDOW_PAIRS = 16,
   parameter int SUM_W        = SAMPLE_W + $clog2(WINDOW_PAIRS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                add,
   input  logic                clear,
   input  logic [SAMPLE_W-1:0] sample_a,
   input  logic [SAMPLE_W-1:0] sample_b,
   output logic [SUM_W-1:0]    sum_a,
   output logic [SUM_W-1:0]    sum_b,
   output logic                last
);

   localparam int CNT_W = (WINDOW_PAIRS > 1) ? $clog2(WINDOW_PAIRS) : 1;

   logic [SUM_W-1:0] sum_a_ff, sum_a_in;
   logic [SUM_W-1:0] sum_b_ff, sum_b_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // the pair now arriving completes the window
   assign last = (count_ff == CNT_W'(WINDOW_PAIRS - 1));

   // accumulate, clear wins
   always_comb begin
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      count_in = count_ff;
      if (clear) begin
         sum_a_in = '0;
         sum_b_in = '0;
         count_in = '0;
      end else if (add) begin
         sum_a_in = sum_a_ff + SUM_W'(sample_a);
         sum_b_in = sum_b_ff + SUM_W'(sample_b);
         count_in = last ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
         count_ff <= '0;
      end else begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
         count_ff <= count_in;
      end
   end

   assign sum_a = sum_a_ff;
   assign sum_b = sum_b_ff;

endmodule

[rtl/core/dcap_serial_div.sv]
// ----------------------------------------------------------------------------
// dcap_serial_div
// restoring divider, one quotient bit per cycle through a shift register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcap_serial_div import dcap_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_sts_type sts
);

   logic [DIV_W-1:0]  dq_ff, dq_in;
   logic [CAL_W-1:0]  rem_ff, rem_in;
   logic [CAL_W-1:0]  dvs_ff, dvs_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [CAL_W:0]    shifted;
   logic [CAL_W+1:0]  diff;

   // trial subtraction of the divisor from the shifted partial remainder
   assign shifted = {rem_ff, dq_ff[DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dq_in   = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // dividend bits leave at the top, quotient bits enter at the bottom
         if (diff[CAL_W+1]) begin
            rem_in = shifted[CAL_W-1:0];
            dq_in  = {dq_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = diff[CAL_W-1:0];
            dq_in  = {dq_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + QCNT_W'(1);
         if (cnt_ff == QCNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = dq_ff;

endmodule

[rtl/core/dcap_pct_prep.sv]
// ----------------------------------------------------------------------------
// dcap_pct_prep
// two stage percent set-up: clamp and span, then scaled rounded numerator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcap_pct_prep import dcap_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic [CAL_W-1:0] level,
   input  logic [CAL_W-1:0] dry,
   input  logic [CAL_W-1:0] wet,
   output pct_sts_type      sts
);

   logic               s1_valid_ff;
   logic               done_ff;
   logic [1:0]         outcome_ff, outcome_in;
   logic [CAL_W-1:0]   pos_ff, pos_in;
   logic [CAL_W-1:0]   span_ff, span_in;
   logic [NUMER_W-1:0] numer_ff, numer_in;

   // stage one: direction, clamping and distances
   always_comb begin
      outcome_in = OUT_DIVIDE;
      pos_in     = '0;
      span_in    = '0;
      if (dry == wet) begin
         outcome_in = OUT_INVALID;
      end else if (dry > wet) begin
         span_in = dry - wet;
         pos_in  = dry - level;
         if (level >= dry) begin
            outcome_in = OUT_ZERO;
         end else if (level <= wet) begin
            outcome_in = OUT_FULL;
         end
      end else begin
         span_in = wet - dry;
         pos_in  = level - dry;
         if (level <= dry) begin
            outcome_in = OUT_ZERO;
         end else if (level >= wet) begin
            outcome_in = OUT_FULL;
         end
      end
   end

   // stage two: pos * 100 + span / 2
   assign numer_in = NUMER_W'(pos_ff) * NUMER_W'(PCT_FULL)
                   + NUMER_W'(span_ff[CAL_W-1:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= load;
         done_ff     <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         outcome_ff <= outcome_in;
         pos_ff     <= pos_in;
         span_ff    <= span_in;
      end
      numer_ff <= numer_in;
   end

   assign sts.done    = done_ff;
   assign sts.outcome = outcome_ff;
   assign sts.numer   = numer_ff;
   assign sts.span    = span_ff;

endmodule
